@@ hdl/nms_pkg.sv @@
package nms_pkg;

  localparam int LINE_DEPTH = 1024;
  localparam int SAMPLE_W   = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int COLCNT_W   = 11;
  localparam int SUM_W      = 10;
  localparam int CNT_W      = 3;
  localparam int MEAN_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int BANKS      = 3;
  localparam int SLOTS      = 3;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  // One pending result: neighbour sum and count plus its matrix position.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } nms_res_t;

  // Mean as unsigned 8.8: floor(sum * 256 / cnt) for cnt of 1 to 4.
  // Division by three uses sum = 3q + rem, so the result is q.frac with
  // frac = floor(256 * rem / 3).
  function automatic logic [MEAN_W-1:0] mean_8p8(input logic [SUM_W-1:0] sum,
                                                 input logic [CNT_W-1:0] cnt);
    logic [19:0]      prod;
    logic [7:0]       q;
    logic [SUM_W-1:0] rem;
    logic [7:0]       frac;
    logic [MEAN_W-1:0] res;
    prod = {10'd0, sum} * 20'd683;
    q    = prod[18:11];
    rem  = sum - ({2'b00, q} * 10'd3);
    case (rem[1:0])
      2'd1:    frac = 8'd85;
      2'd2:    frac = 8'd170;
      default: frac = 8'd0;
    endcase
    case (cnt)
      3'd1:    res = {sum[7:0], 8'd0};
      3'd2:    res = {sum[8:0], 7'd0};
      3'd3:    res = {q, frac};
      3'd4:    res = {sum, 6'd0};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/nms_ram.sv @@
module nms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/neighbour_mean_smoothing_unit.sv @@
// Four-neighbour mean filter over a matrix streamed in raster order.
// Samples enter on the in_ stream, one per beat, in_tdata[7:0]. Each element
// is replaced by the mean of its up, down, left and right neighbours that lie
// inside the matrix, in unsigned 8.8 fixed point; a 1x1 matrix is copied.
// Results leave on the out_ stream in raster order, out_tlast marking the
// frame's last element. Matrix size is set through cfg_we/cfg_index/cfg_data
// (index 0: row count, index 1: column count); each write also restarts the
// frame at row 0, column 0. Write configuration only while the block is idle.
// Throughput is one sample per cycle in all but the last row, unless the
// receiver stalls. In the last row a sample completes up to three results
// (the third at the row's end); while more than one is pending in_tready is
// low, since the output register moves one beat per cycle. The first result
// of a sample passes stage B and the holding stage into the output register;
// the rest follow one per cycle while the receiver is ready. Three line stores
// rotate roles at every row end; all are read per sample, only the current one written.
// Synchronous reset sets row and column counts to one, returns to the frame
// start and empties the pipeline; line store contents are left as they are.
// When the receiver stalls, results queue in a three-entry holding stage and
// then in_tready drops, so nothing is lost.
module neighbour_mean_smoothing_unit
  import nms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] smoothed, [27:16] out_row,
                                             // [37:28] out_column, [39:38] zero
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(LINE_DEPTH);

  // Configuration and raster position.
  logic [ROW_W-1:0]    row_count_r;
  logic [COLCNT_W-1:0] col_count_r;
  logic [ROW_W-1:0]    rows_last;
  logic [COL_W-1:0]    cols_last;
  logic [ROW_W-1:0]    pos_r_r, pos_r_nxt;
  logic [COL_W-1:0]    pos_c_r, pos_c_nxt;
  logic [1:0]          ptr_r, ptr_nxt;
  logic                accept;
  logic                at_last_col;

  // Line store read addresses for the sample being accepted.
  logic [1:0]          wr_prev_idx;
  logic [AW-1:0]       col_next;
  logic [AW-1:0]       bank_raddr [BANKS];

  // Stage B: the item whose line store reads are returning.
  logic                b_valid_r, b_valid_nxt;
  logic [ROW_W-1:0]    b_row_r;
  logic [COL_W-1:0]    b_col_r;
  logic [SAMPLE_W-1:0] b_sample_r;
  logic [1:0]          b_ptr_r;
  logic                b_last_row_r;
  logic                b_last_col_r;
  logic                b_adv;

  // Sliding window: previous row at c and c-1, current row at c-1 and c-2.
  logic [SAMPLE_W-1:0] pw1_r, pw2_r, cw1_r, cw2_r;

  logic [SAMPLE_W-1:0] bank_rd [BANKS];
  logic [1:0]          prev_idx, older_idx;
  logic [SAMPLE_W-1:0] rd_prev, rd_older, rd_cur, row_start;

  // Holding stage for the results of one item.
  nms_res_t            slot_r [SLOTS];
  nms_res_t            b_res  [SLOTS];
  logic [SLOTS-1:0]    b_mask;
  logic [SLOTS-1:0]    mask_r, mask_nxt, mask_after;
  logic [1:0]          sel;
  logic                pop;

  logic                out_valid_r, out_valid_nxt;
  logic [MEAN_W-1:0]   out_mean_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic                out_last_r;

  // Effective sizes: zero counts act as one, columns saturate at the store depth.
  always_comb begin
    rows_last = (row_count_r == '0) ? '0 : row_count_r - 1'b1;
    if (col_count_r == '0) begin
      cols_last = '0;
    end else if (col_count_r > COLCNT_W'(LINE_DEPTH)) begin
      cols_last = COL_W'(LINE_DEPTH - 1);
    end else begin
      cols_last = COL_W'(col_count_r - 1'b1);
    end
  end

  assign accept      = in_tvalid && in_tready;
  assign at_last_col = (pos_c_r == cols_last);

  always_comb begin
    pos_r_nxt = pos_r_r;
    pos_c_nxt = pos_c_r;
    ptr_nxt   = ptr_r;
    if (cfg_we) begin
      pos_r_nxt = '0;
      pos_c_nxt = '0;
    end else if (accept) begin
      if (at_last_col) begin
        pos_c_nxt = '0;
        pos_r_nxt = (pos_r_r == rows_last) ? '0 : pos_r_r + 1'b1;
        ptr_nxt   = (ptr_r == 2'd2) ? 2'd0 : ptr_r + 2'd1;
      end else begin
        pos_c_nxt = pos_c_r + 1'b1;
      end
    end
  end

  // The current row goes into bank ptr. The older row is read at the sample's
  // column and the previous row one column ahead, so the element above is
  // complete as soon as its right neighbour is known. The current bank is
  // read at column 0, which seeds the window when this row becomes the
  // previous one.
  always_comb begin
    wr_prev_idx = (ptr_r == 2'd0) ? 2'd2 : ptr_r - 2'd1;
    col_next    = pos_c_r[AW-1:0] + 1'b1;
    for (int i = 0; i < BANKS; i++) begin
      if (ptr_r == 2'(i)) begin
        bank_raddr[i] = '0;
      end else if (wr_prev_idx == 2'(i)) begin
        bank_raddr[i] = col_next;
      end else begin
        bank_raddr[i] = pos_c_r[AW-1:0];
      end
    end
  end

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    nms_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_line (
      .clk   (clk),
      .we    (accept && (ptr_r == 2'(g))),
      .waddr (pos_c_r[AW-1:0]),
      .wdata (in_tdata[SAMPLE_W-1:0]),
      .re    (accept),
      .raddr (bank_raddr[g]),
      .rdata (bank_rd[g])
    );
  end

  // In a single-column matrix column 0 is written by the same sample, so the
  // sample itself is taken instead of the store.
  always_comb begin
    prev_idx  = (b_ptr_r == 2'd0) ? 2'd2 : b_ptr_r - 2'd1;
    older_idx = (b_ptr_r == 2'd2) ? 2'd0 : b_ptr_r + 2'd1;
    rd_prev   = bank_rd[prev_idx];
    rd_older  = bank_rd[older_idx];
    rd_cur    = bank_rd[b_ptr_r];
    row_start = (b_col_r == '0) ? b_sample_r : rd_cur;
  end

  // Results completed by the item at (r,c), in raster order:
  // slot 0 (r-1,c), and in the last row slot 1 (r,c-1) and slot 2 (r,c) at
  // the row end.
  always_comb begin
    logic r_ge1, r_ge2, c_ge1, c_ge2;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    r_ge1  = (b_row_r != '0);
    r_ge2  = (b_row_r > ROW_W'(1));
    c_ge1  = (b_col_r != '0);
    c_ge2  = (b_col_r > COL_W'(1));
    row_m1 = b_row_r - 1'b1;
    col_m1 = b_col_r - 1'b1;

    b_res[0].sum = (r_ge2 ? SUM_W'(rd_older) : '0) + SUM_W'(b_sample_r)
                 + (c_ge1 ? SUM_W'(pw2_r) : '0)
                 + (!b_last_col_r ? SUM_W'(rd_prev) : '0);
    b_res[0].cnt = CNT_W'(1) + CNT_W'(r_ge2) + CNT_W'(c_ge1) + CNT_W'(!b_last_col_r);
    b_res[0].row = row_m1;
    b_res[0].col = b_col_r;

    b_res[1].sum = (r_ge1 ? SUM_W'(pw2_r) : '0) + (c_ge2 ? SUM_W'(cw2_r) : '0)
                 + SUM_W'(b_sample_r);
    b_res[1].cnt = CNT_W'(1) + CNT_W'(r_ge1) + CNT_W'(c_ge2);
    b_res[1].row = b_row_r;
    b_res[1].col = col_m1;

    // A lone element has no neighbour and is copied.
    if (!r_ge1 && !c_ge1) begin
      b_res[2].sum = SUM_W'(b_sample_r);
      b_res[2].cnt = CNT_W'(1);
    end else begin
      b_res[2].sum = (r_ge1 ? SUM_W'(pw1_r) : '0) + (c_ge1 ? SUM_W'(cw1_r) : '0);
      b_res[2].cnt = CNT_W'(r_ge1) + CNT_W'(c_ge1);
    end
    b_res[2].row = b_row_r;
    b_res[2].col = b_col_r;

    b_mask[0] = r_ge1;
    b_mask[1] = b_last_row_r && c_ge1;
    b_mask[2] = b_last_row_r && b_last_col_r;
  end

  // Pop the lowest pending slot into the output register.
  always_comb begin
    sel = 2'd0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign pop        = (mask_r != '0) && (!out_valid_r || out_tready);
  assign mask_after = pop ? (mask_r & ~(SLOTS'(1) << sel)) : mask_r;
  assign b_adv      = b_valid_r && (mask_after == '0);
  assign in_tready  = !b_valid_r || b_adv;

  assign mask_nxt      = b_adv ? b_mask : mask_after;
  assign b_valid_nxt   = accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);
  assign out_valid_nxt = pop ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_W'(1);
      col_count_r <= COLCNT_W'(1);
      pos_r_r     <= '0;
      pos_c_r     <= '0;
      ptr_r       <= '0;
      b_valid_r   <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT:    row_count_r <= cfg_data;
          REG_COLUMN_COUNT: col_count_r <= cfg_data[COLCNT_W-1:0];
          default: ;
        endcase
      end
      pos_r_r     <= pos_r_nxt;
      pos_c_r     <= pos_c_nxt;
      ptr_r       <= ptr_nxt;
      b_valid_r   <= b_valid_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_row_r      <= pos_r_r;
      b_col_r      <= pos_c_r;
      b_sample_r   <= in_tdata[SAMPLE_W-1:0];
      b_ptr_r      <= ptr_r;
      b_last_row_r <= (pos_r_r == rows_last);
      b_last_col_r <= at_last_col;
    end
    if (b_adv) begin
      // At a row end this row's column 0 becomes the previous row's first entry.
      pw1_r <= b_last_col_r ? row_start : rd_prev;
      pw2_r <= pw1_r;
      cw1_r <= b_sample_r;
      cw2_r <= cw1_r;
      for (int i = 0; i < SLOTS; i++) begin
        slot_r[i] <= b_res[i];
      end
    end
    if (pop) begin
      out_mean_r <= mean_8p8(slot_r[sel].sum, slot_r[sel].cnt);
      out_row_r  <= slot_r[sel].row;
      out_col_r  <= slot_r[sel].col;
      out_last_r <= (sel == 2'(SLOTS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_mean_r};
  assign out_tlast  = out_last_r;

  // The bank pointer only takes the three bank numbers.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r != 2'd3)
    else $error("line store role pointer out of range");

  // The column position never passes the effective last column.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_c_r <= cols_last)
    else $error("column position beyond last column");

  // While stage B waits for the holding stage, its read data must hold.
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !b_adv |=> $stable(rd_prev) && $stable(rd_older))
    else $error("line store read data changed under a stalled item");

  // Pending results always keep the output register busy.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r != '0 |=> out_valid_r)
    else $error("pending result not moved to the output register");

endmodule
